// ----- design/mkrs_pkg.sv -----
// Package for the multi-key record rank select block.
// Holds operation codes, item structs, the sequencer state type and key helpers.
// No dependencies.
package mkrs_pkg;

    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int NAME_BYTES      = 8;
    localparam int KEY_W           = 120;

    localparam logic [63:0] NAME_MASK = ~64'h0 << (64 - 8 * NAME_BYTES);

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]  operation;
        logic [47:0] population;
        logic [7:0]  danger;
        logic [63:0] name_key;
        logic [10:0] rank;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [9:0]  entry_index;
        logic [47:0] out_population;
        logic [7:0]  out_danger;
        logic [63:0] out_name_key;
    } t_out_item;

    typedef struct packed {
        logic [47:0] population;
        logic [7:0]  danger;
        logic [63:0] name_key;
    } t_rec;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_P_RD0,
        S_P_RD0R,
        S_P_LD0,
        S_RD_ORD,
        S_RD_REC,
        S_CMP,
        S_END,
        S_Q_CHK,
        S_Q_REC,
        S_Q_OUT
    } t_state;

    // Larger key comes first: population, then danger, then smaller masked name.
    function automatic logic [KEY_W-1:0] rec_key(input t_rec r);
        rec_key = {r.population, r.danger, ~(r.name_key & NAME_MASK)};
    endfunction

endpackage

// ----- design/mkrs_rec_store.sv -----
// Record memory: population, danger and name per load index.
// Depends on mkrs_pkg (t_rec).
module mkrs_rec_store
    import mkrs_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    localparam int IW = $clog2(MAX_ENTRIES)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [IW-1:0] i_wr_addr,
    input  t_rec          i_wr_data,
    input  logic          i_rd_en,
    input  logic [IW-1:0] i_rd_addr,
    output t_rec          o_rd_data
);

    t_rec r_mem [MAX_ENTRIES];
    t_rec r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/mkrs_order_store.sv -----
// Order memory: load index held at each rank position.
// Depends on mkrs_pkg (defaults).
module mkrs_order_store
    import mkrs_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    localparam int IW = $clog2(MAX_ENTRIES)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [IW-1:0] i_wr_addr,
    input  logic [IW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [IW-1:0] i_rd_addr,
    output logic [IW-1:0] o_rd_data
);

    logic [IW-1:0] r_mem [MAX_ENTRIES];
    logic [IW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/multi_key_record_rank_select_top.sv -----
// Multi-key record rank select. The first query after a load first rebuilds the order:
// it seeds the order memory, then, with two or more records, runs an exchange sort whose
// steps are serialized by the one read port of the order memory and the record memory
// read it feeds. Depends on mkrs_pkg, mkrs_rec_store, mkrs_order_store.
module multi_key_record_rank_select_top
    import mkrs_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    localparam int IW = $clog2(MAX_ENTRIES),
    localparam int CW = $clog2(MAX_ENTRIES + 1),
    localparam int RW = (CW > 11) ? CW : 11
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_ready
);

    t_state r_state, n_state;

    logic [CW-1:0]    r_count;
    logic             r_order_ok;
    logic [10:0]      r_rank;
    logic [IW-1:0]    r_k;       // seed index, or compare position within a pass
    logic [IW-1:0]    r_last;    // last position of the current pass
    logic [IW-1:0]    r_c_idx;   // record being bubbled forward
    logic [KEY_W-1:0] r_c_key;
    logic [IW-1:0]    r_d_idx;   // its right neighbor
    logic [IW-1:0]    r_q_idx;
    logic             r_q_hit;
    logic             r_out_valid;
    t_out_item        r_out_data;

    logic          acc;
    t_op           op;
    logic          c_first;
    logic          in_range;
    logic          out_free;

    logic          rec_wr_en, rec_rd_en;
    logic [IW-1:0] rec_rd_addr;
    t_rec          rec_wr_data, rec_rd_data;

    logic          ord_wr_en, ord_rd_en;
    logic [IW-1:0] ord_wr_addr, ord_wr_data, ord_rd_addr, ord_rd_data;

    assign acc        = i_in_valid && o_in_ready;
    assign op         = t_op'(i_in_data.operation);
    assign o_in_ready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || i_out_ready;
    assign c_first    = r_c_key > rec_key(rec_rd_data);
    assign in_range   = (RW'(r_rank) >= RW'(1)) && (RW'(r_rank) <= RW'(r_count));

    assign rec_wr_data.population = i_in_data.population;
    assign rec_wr_data.danger     = i_in_data.danger;
    assign rec_wr_data.name_key   = i_in_data.name_key;

    mkrs_rec_store #(.MAX_ENTRIES(MAX_ENTRIES)) u_rec (
        .i_clk     (i_clk),
        .i_wr_en   (rec_wr_en),
        .i_wr_addr (r_count[IW-1:0]),
        .i_wr_data (rec_wr_data),
        .i_rd_en   (rec_rd_en),
        .i_rd_addr (rec_rd_addr),
        .o_rd_data (rec_rd_data)
    );

    mkrs_order_store #(.MAX_ENTRIES(MAX_ENTRIES)) u_ord (
        .i_clk     (i_clk),
        .i_wr_en   (ord_wr_en),
        .i_wr_addr (ord_wr_addr),
        .i_wr_data (ord_wr_data),
        .i_rd_en   (ord_rd_en),
        .i_rd_addr (ord_rd_addr),
        .o_rd_data (ord_rd_data)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc && op == OP_QUERY) begin
                    if (r_order_ok || r_count == '0) begin
                        n_state = S_Q_CHK;
                    end else begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                if (CW'(r_k) + CW'(1) == r_count) begin
                    n_state = (r_count >= CW'(2)) ? S_P_RD0 : S_Q_CHK;
                end
            end
            S_P_RD0:  n_state = S_P_RD0R;
            S_P_RD0R: n_state = S_P_LD0;
            S_P_LD0:  n_state = S_RD_ORD;
            S_RD_ORD: n_state = S_RD_REC;
            S_RD_REC: n_state = S_CMP;
            S_CMP:    n_state = (r_k + IW'(1) == r_last) ? S_END : S_RD_ORD;
            S_END:    n_state = (r_last == IW'(1)) ? S_Q_CHK : S_P_RD0;
            S_Q_CHK:  n_state = in_range ? S_Q_REC : S_Q_OUT;
            S_Q_REC:  n_state = S_Q_OUT;
            S_Q_OUT:  n_state = out_free ? S_IDLE : S_Q_OUT;
            default:  n_state = S_IDLE;
        endcase
    end

    // Memory controls.
    always_comb begin
        rec_wr_en   = 1'b0;
        rec_rd_en   = 1'b0;
        rec_rd_addr = ord_rd_data;
        ord_wr_en   = 1'b0;
        ord_wr_addr = r_k;
        ord_wr_data = r_k;
        ord_rd_en   = 1'b0;
        ord_rd_addr = r_k + IW'(1);
        case (r_state)
            S_IDLE: begin
                rec_wr_en = acc && op == OP_LOAD && r_count < CW'(MAX_ENTRIES);
            end
            S_INIT: begin
                ord_wr_en = 1'b1;
            end
            S_P_RD0: begin
                ord_rd_en   = 1'b1;
                ord_rd_addr = '0;
            end
            S_P_RD0R, S_RD_REC, S_Q_REC: begin
                rec_rd_en = 1'b1;
            end
            S_RD_ORD: begin
                ord_rd_en = 1'b1;
            end
            S_CMP: begin
                ord_wr_en   = 1'b1;
                ord_wr_data = c_first ? r_c_idx : r_d_idx;
            end
            S_END: begin
                ord_wr_en   = 1'b1;
                ord_wr_addr = r_last;
                ord_wr_data = r_c_idx;
            end
            S_Q_CHK: begin
                ord_rd_en   = in_range;
                ord_rd_addr = IW'(r_rank - 11'd1);
            end
            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_order_ok  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_Q_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (acc && op == OP_CLEAR) begin
                        r_count    <= '0;
                        r_order_ok <= 1'b0;
                    end else if (acc && op == OP_LOAD) begin
                        if (r_count < CW'(MAX_ENTRIES)) begin
                            r_count <= r_count + CW'(1);
                        end
                        r_order_ok <= 1'b0;
                    end
                end
                S_Q_CHK: r_order_ok <= 1'b1;
                default: begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_rank <= i_in_data.rank;
                r_k    <= '0;
                r_last <= IW'(r_count - CW'(1));
            end
            S_INIT:   r_k <= r_k + IW'(1);
            S_P_RD0R: r_c_idx <= ord_rd_data;
            S_P_LD0: begin
                r_c_key <= rec_key(rec_rd_data);
                r_k     <= '0;
            end
            S_RD_REC: r_d_idx <= ord_rd_data;
            S_CMP: begin
                // Swap the bubbled record for its neighbor only when it strictly comes first.
                if (c_first) begin
                    r_c_idx <= r_d_idx;
                    r_c_key <= rec_key(rec_rd_data);
                end
                r_k <= r_k + IW'(1);
            end
            S_END:   r_last <= r_last - IW'(1);
            S_Q_CHK: r_q_hit <= in_range;
            S_Q_REC: r_q_idx <= ord_rd_data;
            S_Q_OUT: begin
                if (out_free) begin
                    r_out_data.found          <= r_q_hit;
                    r_out_data.entry_index    <= r_q_hit ? 10'(r_q_idx) : 10'd0;
                    r_out_data.out_population <= r_q_hit ? rec_rd_data.population : 48'd0;
                    r_out_data.out_danger     <= r_q_hit ? rec_rd_data.danger : 8'd0;
                    r_out_data.out_name_key   <= r_q_hit ? rec_rd_data.name_key : 64'd0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("record count above capacity");

    a_cmp_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_k < r_last && CW'(r_last) < r_count))
        else $error("compare position outside pass");

    a_clear_inval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (op == OP_CLEAR || op == OP_LOAD)) |=> !r_order_ok)
        else $error("kept order survived a clear or load");

endmodule
